// ===== hw/rtl/qsm_pkg.sv =====
// Shared types and constants for the quadrature speed meter.
// Used by qsm_ctrl, qsm_dp and quadrature_speed_meter; depends on nothing.
package qsm_pkg;

   localparam int COUNT_WIDTH_DEF = 32;

   // Operation codes on the request channel
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_READ   = 1'b1;

   // Configuration register indexes
   localparam logic CSR_PPR    = 1'b0;
   localparam logic CSR_WEIGHT = 1'b1;
   localparam int   CSR_IDX_W  = 1;
   localparam int   CSR_DATA_W = 17;

   localparam logic [15:0] PPR_RESET    = 16'd100;
   localparam logic [16:0] WEIGHT_RESET = 17'd6554;
   localparam logic [16:0] WEIGHT_ONE   = 17'h10000;

   // Quadrature transition table, index = {prev A, prev B, new A, new B}
   localparam logic [15:0] STEP_UP = 16'h2814;
   localparam logic [15:0] STEP_DN = 16'h4182;

   // 60000 * 256 = 7500 << 11: multiply by 7500 bit-serially, shift by 11
   localparam int           RPM_MULT_W = 13;
   localparam logic [12:0]  RPM_MULT   = 13'd7500;
   localparam int           RPM_SHIFT  = 11;
   localparam int           MUL_STEPS  = 13;
   localparam int           MUL_IDX_W  = 4;

   // Denominator 8 * ppr * ms and quotient width
   localparam int DEN_W     = 35;
   localparam int QUO_BITS  = 32;
   localparam int STEP_W    = 5;

   typedef struct packed {
      logic              take_sample;
      logic              start_read;
      logic              mul_step;
      logic              div_step;
      logic              ema_new;
      logic              ema_old;
      logic              ema_round;
      logic [STEP_W-1:0] step;
   } cmd_type;

   typedef struct packed {
      logic ms_zero;
   } status_type;

endpackage

// ===== hw/rtl/qsm_ctrl.sv =====
// Sequencer for the quadrature speed meter: handshakes and datapath commands.
// Depends on qsm_pkg.
module qsm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_operation,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  qsm_pkg::status_type status,
   output qsm_pkg::cmd_type    cmd
);

   typedef enum logic [7:0] {
      ST_IDLE      = 8'b0000_0001,
      ST_CHECK     = 8'b0000_0010,
      ST_MUL       = 8'b0000_0100,
      ST_DIV       = 8'b0000_1000,
      ST_EMA_NEW   = 8'b0001_0000,
      ST_EMA_OLD   = 8'b0010_0000,
      ST_EMA_ROUND = 8'b0100_0000,
      ST_DONE      = 8'b1000_0000
   } state_type;

   state_type                    state_ff, state_in;
   logic [qsm_pkg::STEP_W-1:0]   step_ff, step_in;
   logic                         req_take;

   always_comb begin
      req_stall = !((state_ff == ST_IDLE) || (state_ff == ST_DONE)) ||
                  ((state_ff == ST_DONE) && (req_operation == qsm_pkg::OP_READ));
   end

   assign rsp_valid = (state_ff == ST_DONE);
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      state_in        = state_ff;
      step_in         = step_ff;
      cmd             = '0;
      cmd.step        = step_ff;
      cmd.take_sample = req_take && (req_operation == qsm_pkg::OP_SAMPLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_operation == qsm_pkg::OP_READ)) begin
               cmd.start_read = 1'b1;
               state_in       = ST_CHECK;
            end
         end
         ST_CHECK: begin
            step_in = '0;
            if (status.ms_zero) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            if (step_ff == qsm_pkg::STEP_W'(qsm_pkg::MUL_STEPS - 1)) begin
               step_in  = qsm_pkg::STEP_W'(qsm_pkg::QUO_BITS - 1);
               state_in = ST_DIV;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == '0) begin
               state_in = ST_EMA_NEW;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_EMA_NEW: begin
            cmd.ema_new = 1'b1;
            state_in    = ST_EMA_OLD;
         end
         ST_EMA_OLD: begin
            cmd.ema_old = 1'b1;
            state_in    = ST_EMA_ROUND;
         end
         ST_EMA_ROUND: begin
            cmd.ema_round = 1'b1;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ===== hw/rtl/qsm_dp.sv =====
// Datapath for the quadrature speed meter: pulse counter, shift-add multiplier,
// restoring divider and exponential moving-average filter. Depends on qsm_pkg.
module qsm_dp #(
   parameter int COUNT_WIDTH = qsm_pkg::COUNT_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  qsm_pkg::cmd_type    cmd,
   output qsm_pkg::status_type status,
   input  logic                req_phase_a,
   input  logic                req_phase_b,
   input  logic [15:0]         req_elapsed_ms,
   input  logic [15:0]         ppr,
   input  logic [16:0]         weight,
   output logic signed [31:0]  rsp_speed_rpm,
   output logic                rsp_time_zero_flag
);

   localparam int NUM_W = COUNT_WIDTH + qsm_pkg::RPM_MULT_W + qsm_pkg::RPM_SHIFT;
   localparam int DSH_W = qsm_pkg::DEN_W + qsm_pkg::QUO_BITS - 1;
   localparam int REM_W = (NUM_W > DSH_W) ? NUM_W : DSH_W;

   logic [1:0]                   prev_ff;
   logic [COUNT_WIDTH-1:0]       count_ff, count_in;
   logic [COUNT_WIDTH-1:0]       mag_ff;
   logic                         neg_ff;
   logic                         zero_ff;
   logic [qsm_pkg::DEN_W-1:0]    den_ff;
   logic [REM_W-1:0]             rem_ff, rem_in;
   logic [qsm_pkg::QUO_BITS-1:0] quo_ff, quo_in;
   logic signed [49:0]           prod_ff;
   logic signed [51:0]           sum_ff;
   logic signed [31:0]           smooth_ff, smooth_in;

   logic [3:0]                   step_idx;
   logic [15:0]                  ppr_eff;
   logic [31:0]                  ppr_ms;
   logic [16:0]                  w_new, w_old;
   logic [REM_W-1:0]             addend, den_sh;
   logic [REM_W:0]               diff;
   logic signed [31:0]           raw;
   logic signed [17:0]           mul_a;
   logic signed [31:0]           mul_b;
   logic signed [49:0]           mul_p;
   logic signed [51:0]           rounded;
   logic signed [35:0]           shifted;

   assign step_idx = {prev_ff, req_phase_a, req_phase_b};
   assign ppr_eff  = (ppr == '0) ? 16'd1 : ppr;
   assign ppr_ms   = 32'(ppr_eff) * 32'(req_elapsed_ms);
   assign w_new    = (weight > qsm_pkg::WEIGHT_ONE) ? qsm_pkg::WEIGHT_ONE : weight;
   assign w_old    = qsm_pkg::WEIGHT_ONE - w_new;

   // Pulse counter: step up, down or hold per transition table; clear on read
   always_comb begin
      count_in = count_ff;
      if (cmd.take_sample) begin
         if (qsm_pkg::STEP_UP[step_idx]) begin
            count_in = count_ff + 1'b1;
         end else if (qsm_pkg::STEP_DN[step_idx]) begin
            count_in = count_ff - 1'b1;
         end
      end
      if (cmd.start_read) begin
         count_in = '0;
      end
   end

   // Remainder register: first accumulates |count| * 7500 << 11, then divides
   always_comb begin
      addend = REM_W'(mag_ff) << (cmd.step[qsm_pkg::MUL_IDX_W-1:0] + qsm_pkg::RPM_SHIFT);
      den_sh = REM_W'(den_ff) << cmd.step;
      diff   = {1'b0, rem_ff} - {1'b0, den_sh};
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (cmd.start_read) begin
         rem_in = '0;
         quo_in = '0;
      end else if (cmd.mul_step) begin
         if (qsm_pkg::RPM_MULT[cmd.step[qsm_pkg::MUL_IDX_W-1:0]]) begin
            rem_in = rem_ff + addend;
         end
      end else if (cmd.div_step) begin
         if (!diff[REM_W]) begin
            rem_in               = diff[REM_W-1:0];
            quo_in[cmd.step]     = 1'b1;
         end
      end
   end

   // Signed raw speed, saturated; quotient top bit means at least 2^31
   always_comb begin
      if (neg_ff) begin
         raw = quo_ff[31] ? 32'sh8000_0000 : -$signed(quo_ff);
      end else begin
         raw = quo_ff[31] ? 32'sh7FFF_FFFF : $signed(quo_ff);
      end
   end

   // One shared multiplier for both filter terms
   always_comb begin
      if (cmd.ema_old) begin
         mul_a = $signed({1'b0, w_old});
         mul_b = smooth_ff;
      end else begin
         mul_a = $signed({1'b0, w_new});
         mul_b = raw;
      end
      mul_p = mul_a * mul_b;
   end

   always_comb begin
      rounded   = sum_ff + 52'sd32768;
      shifted   = rounded[51:16];
      smooth_in = smooth_ff;
      if (cmd.ema_round) begin
         if (!shifted[35] && (shifted[34:31] != 4'h0)) begin
            smooth_in = 32'sh7FFF_FFFF;
         end else if (shifted[35] && (shifted[34:31] != 4'hF)) begin
            smooth_in = 32'sh8000_0000;
         end else begin
            smooth_in = shifted[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= '0;
         count_ff  <= '0;
         smooth_ff <= '0;
         zero_ff   <= 1'b0;
      end else begin
         count_ff  <= count_in;
         smooth_ff <= smooth_in;
         if (cmd.take_sample) begin
            prev_ff <= {req_phase_a, req_phase_b};
         end
         if (cmd.start_read) begin
            zero_ff <= (req_elapsed_ms == '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (cmd.start_read) begin
         neg_ff <= count_ff[COUNT_WIDTH-1];
         mag_ff <= count_ff[COUNT_WIDTH-1] ? (~count_ff + 1'b1) : count_ff;
         den_ff <= {ppr_ms, 3'b000};
      end
      if (cmd.ema_new) begin
         prod_ff <= mul_p;
      end
      if (cmd.ema_old) begin
         sum_ff <= 52'(prod_ff) + 52'(mul_p);
      end
   end

   assign status.ms_zero     = zero_ff;
   assign rsp_speed_rpm      = smooth_ff;
   assign rsp_time_zero_flag = zero_ff;

endmodule

// ===== hw/rtl/quadrature_speed_meter.sv =====
// Top level of the quadrature speed meter: configuration registers and the
// controller/datapath pair. Depends on qsm_pkg, qsm_ctrl and qsm_dp.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_stall  operation, phase_a, phase_b, elapsed_ms
//   rsp_      out        rsp_valid / rsp_stall  speed_rpm, time_zero_flag
//   csr_      in         csr_write_en           csr_index, csr_wdata
//
// Samples are taken one per cycle, back to back, while idle or while a result waits.
// A speed read runs through accept, check, 13 shift-add steps of the rate multiplier,
// 32 steps of the restoring divider and the filter steps new term, old term and round;
// with zero elapsed time it skips from check to the result. The divider loop is longest.
// Reset is synchronous and active high; it clears the count, phases and average.
// A read stalls every request until its result is ready, and further reads until taken.
module quadrature_speed_meter #(
   parameter int COUNT_WIDTH = qsm_pkg::COUNT_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_operation,
   input  logic                             req_phase_a,
   input  logic                             req_phase_b,
   input  logic [15:0]                      req_elapsed_ms,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [31:0]               rsp_speed_rpm,
   output logic                             rsp_time_zero_flag,
   input  logic                             csr_write_en,
   input  logic [qsm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [qsm_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic [15:0]          ppr_ff;
   logic [16:0]          weight_ff;
   qsm_pkg::cmd_type     cmd;
   qsm_pkg::status_type  status;

   // Configuration registers: write at the addressed index, no read-back
   always_ff @(posedge clock) begin
      if (reset) begin
         ppr_ff    <= qsm_pkg::PPR_RESET;
         weight_ff <= qsm_pkg::WEIGHT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            qsm_pkg::CSR_PPR:    ppr_ff    <= csr_wdata[15:0];
            qsm_pkg::CSR_WEIGHT: weight_ff <= csr_wdata[16:0];
            default: begin
            end
         endcase
      end
   end

   // Sequence the read: multiply, divide, filter, then hold the result; zero time skips to the result
   qsm_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .status        (status),
      .cmd           (cmd)
   );

   // Count pulses and compute the smoothed speed
   qsm_dp #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_phase_a        (req_phase_a),
      .req_phase_b        (req_phase_b),
      .req_elapsed_ms     (req_elapsed_ms),
      .ppr                (ppr_ff),
      .weight             (weight_ff),
      .rsp_speed_rpm      (rsp_speed_rpm),
      .rsp_time_zero_flag (rsp_time_zero_flag)
   );

endmodule

// ===== verif/quadrature_speed_meter_tb.sv =====
// Self-checking testbench for quadrature_speed_meter: pin-sample and speed-read requests.
// Holds its own prediction of pulse counting and the smoothed speed.
// Depends on qsm_pkg and the quadrature_speed_meter RTL.
module quadrature_speed_meter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Settle longer than a read takes before register writes
   localparam int      SETTLE_CYCLES = 64;
   localparam int      CYCLE_LIMIT   = 400000;
   localparam longint  RPM_SCALE     = 15360000;   // 60000 rpm per edge-per-ms, in Q23.8
   localparam int      SAT_STEPS     = 1120;       // enough edges to saturate with ppr 1, 1 ms
   // Count change per transition, index = {previous A, previous B, new A, new B}
   localparam int      QUAD_STEP [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};

   typedef struct {
      logic signed [31:0] speed_rpm;
      logic               time_zero_flag;
   } speed_result_type;

   logic                              clock;
   logic                              reset          = 1'b1;
   logic                              req_valid      = 1'b0;
   logic                              req_stall;
   logic                              req_operation  = qsm_pkg::OP_SAMPLE;
   logic                              req_phase_a    = 1'b0;
   logic                              req_phase_b    = 1'b0;
   logic [15:0]                       req_elapsed_ms = '0;
   logic                              rsp_valid;
   logic                              rsp_stall      = 1'b0;
   logic signed [31:0]                rsp_speed_rpm;
   logic                              rsp_time_zero_flag;
   logic                              csr_write_en   = 1'b0;
   logic [qsm_pkg::CSR_IDX_W-1:0]     csr_index      = '0;
   logic [qsm_pkg::CSR_DATA_W-1:0]    csr_wdata      = '0;

   // Predicted block state and configuration, as after reset
   logic [1:0]               last_phases = 2'b00;
   logic [31:0]              pulse_total = '0;
   logic signed [31:0]       avg_speed   = '0;
   logic [15:0]              ppr_reg     = 16'd100;
   logic [16:0]              weight_reg  = 17'd6554;

   speed_result_type         expected_speeds [$];
   logic [1:0]               encoder_phases = 2'b00;   // phases last driven on the pins
   bit                       steady = 1'b0;            // no idling on either side while set
   int                       mismatch_count = 0;
   int                       requests_sent  = 0;
   int                       reads_sent     = 0;
   int                       cycle_count    = 0;

   quadrature_speed_meter DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_phase_a        (req_phase_a),
      .req_phase_b        (req_phase_b),
      .req_elapsed_ms     (req_elapsed_ms),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_speed_rpm      (rsp_speed_rpm),
      .rsp_time_zero_flag (rsp_time_zero_flag),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // ---------------------------------------------------------------- prediction

   function automatic logic signed [31:0] clamp_to_32(input longint v);
      if (v > 64'sd2147483647)
         return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648)
         return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // Advance the pulse count by one pin sample
   function automatic void track_phase_sample(input logic a, input logic b);
      int delta;
      delta = QUAD_STEP[{last_phases, a, b}];
      if (delta > 0)
         pulse_total = pulse_total + 32'd1;
      else if (delta < 0)
         pulse_total = pulse_total - 32'd1;
      last_phases = {a, b};
   endfunction

   // Take and clear the count; unless the time is zero, turn it into rpm and blend it into the average
   function automatic speed_result_type predict_speed_read(input logic [15:0] ms);
      speed_result_type res;
      longint taken, mag, den, quo, rem, rate, weight, blend;
      logic signed [31:0] raw;
      taken = longint'(signed'(pulse_total));
      pulse_total = '0;
      res.time_zero_flag = (ms == 16'd0);
      if (ms != 16'd0) begin
         den = 64'sd8 * longint'(ppr_reg == 16'd0 ? 16'd1 : ppr_reg) * longint'(ms);
         mag = (taken < 0) ? -taken : taken;
         quo = mag / den;
         rem = mag % den;
         rate = quo * RPM_SCALE + (rem * RPM_SCALE) / den;
         if (rate > 64'sh1_0000_0000)
            rate = 64'sh1_0000_0000;
         raw = clamp_to_32((taken < 0) ? -rate : rate);
         // weights above 1.0 act as 1.0
         weight = (weight_reg > 17'h10000) ? 64'sd65536 : longint'(weight_reg);
         blend = weight * raw + (64'sd65536 - weight) * avg_speed + 64'sd32768;
         avg_speed = clamp_to_32(blend >>> 16);   // floor division by 65536
      end
      res.speed_rpm = avg_speed;
      return res;
   endfunction

   // ---------------------------------------------------------------- driving

   function automatic bit take_break();
      return !steady && ($urandom_range(0, 99) < 22);
   endfunction

   // Idle the response side at random; change only on the falling edge
   always @(negedge clock)
      rsp_stall <= take_break();

   // Drive one request and hold it until the block takes it, then predict its effect
   task automatic send_request(input logic op, input logic a, input logic b,
                               input logic [15:0] ms);
      @(negedge clock);
      while (take_break()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_phase_a    <= a;
      req_phase_b    <= b;
      req_elapsed_ms <= ms;
      do
         @(posedge clock);
      while (req_stall);
      requests_sent++;
      if (op == qsm_pkg::OP_SAMPLE) begin
         track_phase_sample(a, b);
      end else begin
         reads_sent++;
         expected_speeds.push_back(predict_speed_read(ms));
      end
   endtask

   // Drop valid and hold until every expected result has come, optionally let the block settle
   task automatic wait_for_speeds(input bit settle);
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_speeds.size() != 0)
         @(posedge clock);
      if (settle)
         repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [qsm_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [qsm_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      if (idx == qsm_pkg::CSR_PPR)
         ppr_reg = data[15:0];
      else if (idx == qsm_pkg::CSR_WEIGHT)
         weight_reg = data[16:0];
   endtask

   // Bring the block to rest, then write both registers
   task automatic configure(input logic [qsm_pkg::CSR_DATA_W-1:0] ppr_data,
                            input logic [qsm_pkg::CSR_DATA_W-1:0] weight_data);
      wait_for_speeds(1'b1);
      write_register(qsm_pkg::CSR_PPR, ppr_data);
      write_register(qsm_pkg::CSR_WEIGHT, weight_data);
   endtask

   // Drive the pins one Gray-code step; elapsed_ms carries junk since samples ignore it
   task automatic move_encoder(input bit backward);
      logic [1:0] nxt;
      case (encoder_phases)
         2'b00: nxt = backward ? 2'b01 : 2'b10;
         2'b10: nxt = backward ? 2'b00 : 2'b11;
         2'b11: nxt = backward ? 2'b10 : 2'b01;
         default: nxt = backward ? 2'b11 : 2'b00;
      endcase
      encoder_phases = nxt;
      send_request(qsm_pkg::OP_SAMPLE, nxt[1], nxt[0], 16'($urandom));
   endtask

   task automatic drive_pins(input logic [1:0] pins);
      encoder_phases = pins;
      send_request(qsm_pkg::OP_SAMPLE, pins[1], pins[0], 16'($urandom));
   endtask

   // Reads ignore the phase pins, so put junk on them
   task automatic read_speed(input logic [15:0] ms);
      send_request(qsm_pkg::OP_READ, 1'($urandom), 1'($urandom), ms);
   endtask

   function automatic logic [15:0] pick_elapsed();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 5)
         return 16'd0;
      if (roll < 75)
         return 16'($urandom_range(1, 20));
      return 16'($urandom_range(0, 65535));
   endfunction

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin
      speed_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_speeds.size() == 0) begin
            mismatch_count++;
            $display("%0t: result with none expected, speed_rpm %0d, time_zero_flag %0b",
                     $time, rsp_speed_rpm, rsp_time_zero_flag);
         end else begin
            want = expected_speeds.pop_front();
            if (rsp_speed_rpm !== want.speed_rpm) begin
               mismatch_count++;
               $display("%0t: speed_rpm expected %0d, actual %0d",
                        $time, want.speed_rpm, rsp_speed_rpm);
            end
            if (rsp_time_zero_flag !== want.time_zero_flag) begin
               mismatch_count++;
               $display("%0t: time_zero_flag expected %0b, actual %0b",
                        $time, want.time_zero_flag, rsp_time_zero_flag);
            end
         end
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests

   // Reset settings: zero time, both directions, illegal jumps, extreme elapsed times
   task automatic test_basic_reads();
      read_speed(16'd0);                       // empty count, zero time: average held
      repeat (4) move_encoder(1'b0);
      read_speed(16'd1);
      drive_pins(2'b11);                       // double jumps count nothing
      drive_pins(2'b00);
      drive_pins(2'b00);                       // no movement
      repeat (3) move_encoder(1'b1);
      read_speed(16'hFFFF);
      repeat (2) move_encoder(1'b0);
      read_speed(16'd0);                       // count taken and dropped, average held
      read_speed(16'd7);                       // count must be clear now
   endtask

   // Zero ppr acts as one, weight 1.0, weight 0 and weight above 1.0
   task automatic test_register_extremes();
      configure(17'd0, 17'h10000);
      repeat (2) move_encoder(1'b0);
      read_speed(16'd1);
      configure(17'hFFFF, 17'd0);
      repeat (5) move_encoder(1'b1);
      read_speed(16'd3);
      configure(17'h1_0001, 17'h1FFFF);        // bit 16 of a ppr write is dropped
      move_encoder(1'b0);
      read_speed(16'd2);
   endtask

   // Drive the raw speed past both ends of the 32-bit range
   task automatic test_saturation();
      configure(17'd1, 17'h10000);
      steady = 1'b1;
      repeat (SAT_STEPS) move_encoder(1'b0);
      read_speed(16'd1);
      repeat (SAT_STEPS) move_encoder(1'b1);
      read_speed(16'd1);
      steady = 1'b0;
   endtask

   // Mostly clean encoder motion followed by a read, some pin noise, over several settings
   task automatic test_random_traffic();
      int phase_no, start_requests, start_reads, phase_start, steps;
      bit backward;
      phase_no = 0;
      start_requests = requests_sent;
      start_reads = reads_sent;
      while (requests_sent - start_requests < 700 || reads_sent - start_reads < 48) begin
         case (phase_no)
            0: configure(17'd100, 17'd6554);
            1: configure(17'd1, 17'h10000);
            2: configure(17'hFFFF, 17'd0);
            3: configure(17'd4, 17'd32768);
            default: configure({1'($urandom),
                                ($urandom_range(0, 1) ? 16'($urandom_range(1, 16))
                                                      : 16'($urandom_range(0, 65535)))},
                               17'($urandom_range(0, 131071)));
         endcase
         steady = (phase_no == 0);
         phase_start = requests_sent;
         while (requests_sent - phase_start < 150) begin
            if ($urandom_range(0, 99) < 80) begin
               steps = $urandom_range(1, 30);
               backward = 1'($urandom);
               repeat (steps) begin
                  if ($urandom_range(0, 19) == 0)
                     backward = !backward;
                  if ($urandom_range(0, 3) == 0)
                     drive_pins(encoder_phases);    // sampled between edges
                  else
                     move_encoder(backward);
               end
               read_speed(pick_elapsed());
            end else begin
               repeat ($urandom_range(1, 8)) drive_pins(2'($urandom));
               if ($urandom_range(0, 1))
                  read_speed(pick_elapsed());
            end
            // now and then hold off until every result is back
            if ($urandom_range(0, 11) == 0)
               wait_for_speeds(1'b0);
         end
         phase_no++;
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_basic_reads();
      test_register_extremes();
      test_saturation();
      test_random_traffic();
      wait_for_speeds(1'b1);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/qsm_pkg.sv
hw/rtl/qsm_ctrl.sv
hw/rtl/qsm_dp.sv
hw/rtl/quadrature_speed_meter.sv
verif/quadrature_speed_meter_tb.sv
